// ===== rtl/fbdrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fbdrf_pkg : shared types and constants of the dirty row finder
// Item layouts, controller command and status groups, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package fbdrf_pkg;

  localparam int DATA_W     = 32;
  localparam int WADDR_W    = 16;
  localparam int LAG_W      = 4;
  localparam int ROW_OUT_W  = 9;

  // lag thresholds: below LAG_HALF all rows, below LAG_QUARTER half, else quarter
  localparam logic [LAG_W-1:0] LAG_HALF    = 4'd4;
  localparam logic [LAG_W-1:0] LAG_QUARTER = 4'd6;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_COLOR_MODE = 1'b0;  // register index, paddr[2]

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [WADDR_W-1:0] word_addr;
    logic [DATA_W-1:0]  word_data;
    logic [LAG_W-1:0]   time_adjust;
    logic               force_full;
  } in_item_t;

  typedef struct packed {
    logic                 changed;
    logic [ROW_OUT_W-1:0] top_row;
    logic [ROW_OUT_W-1:0] bottom_row;
  } out_item_t;

  typedef struct packed {
    logic wr_word;   // store the input word
    logic clear;     // write zero to both stores at the sweep address
    logic load_up;   // point at the first word of start_row
    logic load_dn;   // point at the last word before start_row
    logic issue;     // read both stores and advance
    logic dir_dn;    // advance downward
    logic copy;      // copy the word in flight into the shadow
  } fbdrf_cmd_t;

  typedef struct packed {
    logic mismatch;   // word in flight differs
    logic tag_vld;    // a read is in flight
    logic addr_zero;  // address counter at word 0
    logic clr_last;   // sweep address at the last word
  } fbdrf_status_t;

endpackage

`default_nettype wire

// ===== rtl/fbdrf_if.sv =====
// ----------------------------------------------------------------------------
// fbdrf_if : input and result channels
// Valid/ready channels carrying one input item or one result item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbdrf_in_if;
  import fbdrf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbdrf_out_if;
  import fbdrf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbdrf_datapath.sv =====
// ----------------------------------------------------------------------------
// fbdrf_datapath : frame store, shadow store and scan address counters
// Holds both stores, walks row/column/address counters and compares words.
// ----------------------------------------------------------------------------
`default_nettype none

module fbdrf_datapath #(
  parameter int ROWS            = 342,
  parameter int MONO_ROW_WORDS  = 16,
  parameter int COLOR_ROW_WORDS = 128,
  parameter int ROW_W           = $clog2(ROWS + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     color_mode_i,
  input  wire fbdrf_pkg::fbdrf_cmd_t    cmd_i,
  input  wire logic [ROW_W-1:0]         start_row_i,
  input  wire fbdrf_pkg::in_item_t      in_data_i,
  output fbdrf_pkg::fbdrf_status_t      status_o,
  output logic [ROW_W-1:0]              row_o,
  output logic [ROW_W-1:0]              tag_row_o
);
  import fbdrf_pkg::*;

  localparam int MAXS   = (COLOR_ROW_WORDS > MONO_ROW_WORDS) ? COLOR_ROW_WORDS
                                                             : MONO_ROW_WORDS;
  localparam int STORE_WORDS = ROWS * MAXS;
  localparam int AW     = $clog2(STORE_WORDS + 1);
  localparam int AIW    = $clog2(STORE_WORDS);
  localparam int SW     = $clog2(MAXS + 1);
  localparam int CW     = (MAXS > 1) ? $clog2(MAXS) : 1;
  localparam int PW     = ROW_W + SW;
  localparam int CMPW   = (AW > WADDR_W) ? AW : WADDR_W;

  logic [SW-1:0]     stride;
  logic [SW-1:0]     stride_m1;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     addr_q, addr_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic              tag_vld_q;
  logic [ROW_W-1:0]  tag_row_q;
  logic [AIW-1:0]    tag_addr_q;
  logic [DATA_W-1:0] cur_rd_q;
  logic [DATA_W-1:0] shd_rd_q;
  logic [CMPW-1:0]   wa_ext;
  logic              wa_ok;
  logic              cur_we;
  logic [AIW-1:0]    cur_wa;
  logic [DATA_W-1:0] cur_wd;
  logic              shd_we;
  logic [AIW-1:0]    shd_wa;
  logic [DATA_W-1:0] shd_wd;

  logic [DATA_W-1:0] cur_mem [STORE_WORDS];
  logic [DATA_W-1:0] shd_mem [STORE_WORDS];

  assign stride    = color_mode_i ? SW'(COLOR_ROW_WORDS) : SW'(MONO_ROW_WORDS);
  assign stride_m1 = stride - SW'(1);
  assign prod      = PW'(start_row_i) * PW'(stride);

  // counters: load at a row boundary, then step one word per read or per sweep write
  always_comb begin
    addr_d = addr_q;
    row_d  = row_q;
    col_d  = col_q;
    if (cmd_i.clear) begin
      addr_d = addr_q + AW'(1);
    end else if (cmd_i.load_up) begin
      addr_d = prod[AW-1:0];
      row_d  = start_row_i;
      col_d  = '0;
    end else if (cmd_i.load_dn) begin
      addr_d = prod[AW-1:0] - AW'(1);
      row_d  = start_row_i - ROW_W'(1);
      col_d  = CW'(stride_m1);
    end else if (cmd_i.issue) begin
      if (cmd_i.dir_dn) begin
        addr_d = addr_q - AW'(1);
        if (col_q == '0) begin
          col_d = CW'(stride_m1);
          row_d = row_q - ROW_W'(1);
        end else begin
          col_d = col_q - CW'(1);
        end
      end else begin
        addr_d = addr_q + AW'(1);
        if (col_q == CW'(stride_m1)) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      tag_vld_q <= 1'b0;
    end else begin
      addr_q    <= addr_d;
      row_q     <= row_d;
      col_q     <= col_d;
      tag_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      tag_row_q  <= row_q;
      tag_addr_q <= addr_q[AIW-1:0];
    end
  end

  // write ports: frame store takes input words or the sweep, shadow the sweep or the copy
  assign wa_ext = CMPW'(in_data_i.word_addr);
  assign wa_ok  = wa_ext < CMPW'(STORE_WORDS);

  always_comb begin
    cur_we = 1'b0;
    cur_wa = addr_q[AIW-1:0];
    cur_wd = '0;
    if (cmd_i.clear) begin
      cur_we = 1'b1;
    end else if (cmd_i.wr_word && wa_ok) begin
      cur_we = 1'b1;
      cur_wa = wa_ext[AIW-1:0];
      cur_wd = in_data_i.word_data;
    end
    shd_we = 1'b0;
    shd_wa = addr_q[AIW-1:0];
    shd_wd = '0;
    if (cmd_i.clear) begin
      shd_we = 1'b1;
    end else if (cmd_i.copy && tag_vld_q) begin
      shd_we = 1'b1;
      shd_wa = tag_addr_q;
      shd_wd = cur_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cmd_i.issue) begin
      cur_rd_q <= cur_mem[addr_q[AIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shd_we) begin
      shd_mem[shd_wa] <= shd_wd;
    end
    if (cmd_i.issue) begin
      shd_rd_q <= shd_mem[addr_q[AIW-1:0]];
    end
  end

  assign status_o.mismatch  = tag_vld_q && (cur_rd_q != shd_rd_q);
  assign status_o.tag_vld   = tag_vld_q;
  assign status_o.addr_zero = (addr_q == '0);
  assign status_o.clr_last  = (addr_q == AW'(STORE_WORDS - 1));
  assign row_o              = row_q;
  assign tag_row_o          = tag_row_q;

endmodule

`default_nettype wire

// ===== rtl/fbdrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbdrf_ctrl : sequencer of the dirty row finder
// Runs the clearing sweep, the forward and backward scans and the row copy.
// ----------------------------------------------------------------------------
`default_nettype none

module fbdrf_ctrl #(
  parameter int ROWS  = 342,
  parameter int ROW_W = $clog2(ROWS + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire fbdrf_pkg::in_item_t      in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output fbdrf_pkg::out_item_t          out_data_o,
  output fbdrf_pkg::fbdrf_cmd_t         cmd_o,
  output logic [ROW_W-1:0]              start_row_o,
  input  wire fbdrf_pkg::fbdrf_status_t status_i,
  input  wire logic [ROW_W-1:0]         row_i,
  input  wire logic [ROW_W-1:0]         tag_row_i
);
  import fbdrf_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FWD   = 3'd2;
  localparam logic [2:0] ST_BWDLD = 3'd3;
  localparam logic [2:0] ST_BWD   = 3'd4;
  localparam logic [2:0] ST_COPY  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [ROW_W-1:0] BAND_FULL    = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0] BAND_HALF    = ROW_W'(ROWS / 2);
  localparam logic [ROW_W-1:0] BAND_QUARTER = ROW_W'(ROWS / 4);

  function automatic logic [ROW_OUT_W-1:0] to_out(input logic [ROW_W-1:0] r);
    logic [ROW_W+ROW_OUT_W-1:0] e;
    e = {{ROW_OUT_W{1'b0}}, r};
    return e[ROW_OUT_W-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [ROW_W-1:0] resume_q, resume_d;
  logic [ROW_W-1:0] band_q, band_d;
  logic [ROW_W-1:0] top_q, top_d;
  logic [ROW_W-1:0] bot_q, bot_d;
  logic [ROW_W-1:0] limit_q, limit_d;
  logic [ROW_W-1:0] endr_q, endr_d;
  logic             chg_q, chg_d;
  logic             iss_done_q, iss_done_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_q, out_d;
  logic             issue;
  logic [ROW_W:0]   sum;

  assign sum = {1'b0, tag_row_i} + {1'b0, band_q};

  always_comb begin
    state_d     = state_q;
    resume_d    = resume_q;
    band_d      = band_q;
    top_d       = top_q;
    bot_d       = bot_q;
    limit_d     = limit_q;
    endr_d      = endr_q;
    chg_d       = chg_q;
    iss_done_d  = iss_done_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    cmd_o       = '0;
    start_row_o = resume_q;
    issue       = 1'b0;
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.mode == MODE_WRITE) begin
            cmd_o.wr_word = 1'b1;
          end else begin
            if (in_data_i.time_adjust < LAG_HALF) begin
              band_d = BAND_FULL;
            end else if (in_data_i.time_adjust < LAG_QUARTER) begin
              band_d = BAND_HALF;
            end else begin
              band_d = BAND_QUARTER;
            end
            endr_d        = ROW_W'(ROWS);
            cmd_o.load_up = 1'b1;
            if (in_data_i.force_full) begin
              start_row_o = '0;
              top_d       = '0;
              bot_d       = ROW_W'(ROWS);
              chg_d       = 1'b1;
              state_d     = ST_COPY;
            end else begin
              state_d = ST_FWD;
            end
          end
        end
      end
      ST_FWD: begin
        issue       = !status_i.mismatch && (row_i < endr_q);
        cmd_o.issue = issue;
        if (status_i.mismatch) begin
          top_d = tag_row_i;
          if (sum >= (ROW_W+1)'(ROWS)) begin
            limit_d  = ROW_W'(ROWS);
            resume_d = '0;
          end else begin
            limit_d  = sum[ROW_W-1:0];
            resume_d = sum[ROW_W-1:0];
          end
          state_d = ST_BWDLD;
        end else if (!issue && !status_i.tag_vld) begin
          resume_d = '0;
          chg_d    = 1'b0;
          top_d    = '0;
          bot_d    = '0;
          state_d  = ST_DONE;
        end
      end
      ST_BWDLD: begin
        start_row_o   = limit_q;
        cmd_o.load_dn = 1'b1;
        iss_done_d    = 1'b0;
        state_d       = ST_BWD;
      end
      ST_BWD: begin
        issue        = !status_i.mismatch && !iss_done_q;
        cmd_o.issue  = issue;
        cmd_o.dir_dn = 1'b1;
        if (issue && status_i.addr_zero) begin
          iss_done_d = 1'b1;
        end
        start_row_o = top_q;
        if (status_i.mismatch || (!issue && !status_i.tag_vld)) begin
          // without a hit from below the band ends one row past its top
          if (status_i.mismatch) begin
            bot_d = tag_row_i + ROW_W'(1);
          end else begin
            bot_d = top_q + ROW_W'(1);
          end
          endr_d        = bot_d;
          chg_d         = 1'b1;
          cmd_o.dir_dn  = 1'b0;
          cmd_o.load_up = 1'b1;
          state_d       = ST_COPY;
        end
      end
      ST_COPY: begin
        issue       = (row_i < endr_q);
        cmd_o.issue = issue;
        cmd_o.copy  = 1'b1;
        if (!issue && !status_i.tag_vld) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d        = 1'b1;
          out_d.changed    = chg_q;
          out_d.top_row    = to_out(top_q);
          out_d.bottom_row = to_out(bot_q);
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      resume_q   <= '0;
      iss_done_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      resume_q   <= resume_d;
      iss_done_q <= iss_done_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    band_q  <= band_d;
    top_q   <= top_d;
    bot_q   <= bot_d;
    limit_q <= limit_d;
    endr_q  <= endr_d;
    chg_q   <= chg_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/framebuffer_dirty_row_finder.sv =====
// ----------------------------------------------------------------------------
// framebuffer_dirty_row_finder : top level
// Frame store with shadow copy; a tick finds, copies and reports the band
// of rows that changed since the last tick.
//
//   channel   dir   kind            beat contents
//   in_i      in    valid/ready     mode, word_addr, word_data, time_adjust,
//                                   force_full
//   out_o     out   valid/ready     changed, top_row, bottom_row (ticks only)
//   psel..    in    APB write/read  color_mode at byte address 0
//
// A write beat stores its word; words may follow back to back.
// A tick walks the stores one word per cycle through the read port of each
// memory: forward scan from the resume row, backward scan from the band
// limit, then the copy of the band.
// A forced tick copies all ROWS * stride words.
// After reset a clearing sweep zeros all ROWS * max stride words of both
// stores (43776 at the default sizes); in_i.ready stays low during it.
// A stalled result holds in the output register; write beats still enter.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_dirty_row_finder #(
  parameter int ROWS            = 342,
  parameter int MONO_ROW_WORDS  = 16,
  parameter int COLOR_ROW_WORDS = 128
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fbdrf_in_if.sink                             in_i,
  fbdrf_out_if.source                          out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbdrf_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fbdrf_pkg::PDATA_W-1:0]   pwdata,
  output logic [fbdrf_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready
);
  import fbdrf_pkg::*;

  localparam int ROW_W = $clog2(ROWS + 1);

  logic             color_mode_q;
  fbdrf_cmd_t       cmd;
  fbdrf_status_t    status;
  logic [ROW_W-1:0] start_row;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] tag_row;

  // configuration port: no wait states, register index in paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_COLOR_MODE)) begin
      color_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COLOR_MODE) begin
      prdata[0] = color_mode_q;
    end
  end

  // sequencer: owns the handshakes and the result register
  fbdrf_ctrl #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data),
    .cmd_o       (cmd),
    .start_row_o (start_row),
    .status_i    (status),
    .row_i       (row),
    .tag_row_i   (tag_row)
  );

  // stores and address walk
  fbdrf_datapath #(
    .ROWS            (ROWS),
    .MONO_ROW_WORDS  (MONO_ROW_WORDS),
    .COLOR_ROW_WORDS (COLOR_ROW_WORDS),
    .ROW_W           (ROW_W)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_mode_i (color_mode_q),
    .cmd_i        (cmd),
    .start_row_i  (start_row),
    .in_data_i    (in_i.data),
    .status_o     (status),
    .row_o        (row),
    .tag_row_o    (tag_row)
  );

endmodule

`default_nettype wire

// ===== rtl/fbdrf_checker.sv =====
// ----------------------------------------------------------------------------
// fbdrf_checker : port-level checks of the dirty row finder
// Watches the channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module fbdrf_checker #(
  parameter int ROWS = 342
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire fbdrf_pkg::in_item_t  in_data_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire fbdrf_pkg::out_item_t out_data_i
);
  import fbdrf_pkg::*;

  localparam bit ROWS_FIT = (ROWS < (1 << ROW_OUT_W));

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // a reported band is nonempty and inside the frame
  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.changed |->
      !ROWS_FIT || ((out_data_i.top_row < out_data_i.bottom_row) &&
                    (out_data_i.bottom_row <= ROW_OUT_W'(ROWS))))
    else $error("band out of order or beyond the last row");

  // no change reports rows zero
  a_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.changed |->
      (out_data_i.top_row == '0) && (out_data_i.bottom_row == '0))
    else $error("no-change result carries rows");

  // a tick beat makes the block busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_data_i.mode == MODE_TICK) |=> !in_ready_i)
    else $error("ready stayed high after a tick");

endmodule

bind framebuffer_dirty_row_finder fbdrf_checker #(.ROWS(ROWS)) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
